>>> rtl/bounded_ordered_list_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered list
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication.
`define BOL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_ordered_list assertion failed");

// Next-cycle implication.
`define BOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_ordered_list assertion failed");

`endif

>>> rtl/bol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_pkg
// Command and status codes and the cell control word of the ordered list.
// ----------------------------------------------------------------------------
package bol_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_REMOVE     = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic remove;
  } bol_ctrl_t;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 5;

endpackage

>>> rtl/bol_prefix_or.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_prefix_or
// Parallel-prefix OR: bit i of the result is the OR of input bits 0 to i.
// ----------------------------------------------------------------------------
module bol_prefix_or #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0] in_bits,
  output logic [N-1:0] out_bits
);

  localparam int unsigned Levels = (N > 1) ? $clog2(N) : 0;

  logic [N-1:0] lvl [0:Levels];

  assign lvl[0] = in_bits;

  for (genvar k = 0; k < Levels; k++) begin : g_level
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign out_bits = lvl[Levels];

endmodule

>>> rtl/bol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_cell
// One list slot: holds a word and its valid flag, and loads from the left
// neighbor, the right neighbor or the input word as the operation demands.
// ----------------------------------------------------------------------------
module bol_cell import bol_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bol_ctrl_t                    ctrl,
  input  logic signed [ValueWidth-1:0] value,
  input  logic                         left_valid,
  input  logic signed [ValueWidth-1:0] left_entry,
  input  logic                         right_valid,
  input  logic signed [ValueWidth-1:0] right_entry,
  input  logic                         shift_left,
  output logic                         valid,
  output logic signed [ValueWidth-1:0] entry,
  output logic                         match
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic signed [ValueWidth-1:0] entry_r;
  logic signed [ValueWidth-1:0] entry_nxt;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    priority if (ctrl.push_front) begin
      valid_nxt = left_valid;
      entry_nxt = left_entry;
    end else if (ctrl.push_back) begin
      if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        entry_nxt = value;
      end
    end else if (ctrl.remove) begin
      if (shift_left) begin
        valid_nxt = right_valid;
        entry_nxt = right_entry;
      end
    end else begin
      valid_nxt = valid_r;
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;
  assign match = valid_r && (entry_r == value);

endmodule

>>> rtl/bounded_ordered_list.sv
`timescale 1ns / 1ps
// A word's result is registered and shown in the cycle after acceptance.
// Throughput: one word per cycle; all cells compare and load in parallel,
// and the first-match flag comes from a $clog2(DEPTH)-level prefix-OR tree.
// The output register frees when its result is taken, so input stalls only
// under output back-pressure. Reset empties the list; no clearing pass.
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of signed words built as a row of cells with push at head,
// push at tail and remove of the first matching word.
// ----------------------------------------------------------------------------
module bounded_ordered_list import bol_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic signed [ValueWidth-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [CountWidth-1:0]        out_entry_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                         accept;
  bol_ctrl_t                    ctrl;
  logic [DEPTH-1:0]             cell_valid;
  logic signed [ValueWidth-1:0] cell_entry [0:DEPTH-1];
  logic [DEPTH-1:0]             cell_match;
  logic [DEPTH-1:0]             match_prefix;
  logic                         full;
  logic                         found;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  status_t       status_r;
  status_t       status_nxt;
  logic [31:0]   count_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(DEPTH));
  assign found    = match_prefix[DEPTH-1];

  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = ST_DONE;
      unique case (cmd_t'(in_command))
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.push_front = (cmd_t'(in_command) == CMD_PUSH_FRONT);
            ctrl.push_back  = (cmd_t'(in_command) == CMD_PUSH_BACK);
            count_nxt       = count_r + CW'(1);
          end
        end
        CMD_REMOVE: begin
          if (found) begin
            ctrl.remove = 1'b1;
            count_nxt   = count_r - CW'(1);
          end else begin
            status_nxt = ST_MISSING;
          end
        end
        CMD_NOP: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         lv;
    logic signed [ValueWidth-1:0] le;
    logic                         rv;
    logic signed [ValueWidth-1:0] re;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign le = in_value;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign le = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = in_value;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
    end

    bol_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .value       (in_value),
      .left_valid  (lv),
      .left_entry  (le),
      .right_valid (rv),
      .right_entry (re),
      .shift_left  (match_prefix[i]),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i]),
      .match       (cell_match[i])
    );
  end

  bol_prefix_or #(.N(DEPTH)) u_prefix (
    .in_bits  (cell_match),
    .out_bits (match_prefix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign count_ext       = 32'(count_r);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = count_ext[CountWidth-1:0];

endmodule

>>> rtl/bol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bol_checker
// Port-level checks of the ordered list, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_assert.svh"

module bol_checker import bol_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   in_command,
  input logic signed [ValueWidth-1:0] in_value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic [CountWidth-1:0]        out_entry_count
);

  `BOL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_entry_count))
  `BOL_ASSERT_NEXT(a_word_result, clk, rst_n, in_valid && in_ready, out_valid)
  `BOL_ASSERT_NEXT(a_nop_done, clk, rst_n, in_valid && in_ready && (in_command == CMD_NOP), out_status == ST_DONE)
  `BOL_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL), out_entry_count == CountWidth'(DEPTH))

endmodule

bind bounded_ordered_list bol_checker #(.DEPTH(DEPTH)) u_bol_checker (.*);

>>> verif/tb_bounded_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list
// Drives command and value words into the ordered list and compares every
// status and entry count against a scoreboard that keeps its own copy of the
// list. A directed run covers the empty, full, duplicate and no-op cases, then
// random words run in filling, draining and balanced phases, picked at random,
// with random idle cycles on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list import bol_pkg::*;;

  localparam int unsigned ListDepth  = 16;
  localparam int unsigned RandWords  = 1600;
  localparam int unsigned CycleLimit = 400000;

  class list_scoreboard;
    logic [ValueWidth-1:0] held[ListDepth];
    int unsigned           held_count;
    status_t               exp_status[$];
    logic [CountWidth-1:0] exp_count[$];
    int unsigned           mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function void note_word(cmd_t cmd, logic [ValueWidth-1:0] value);
      status_t     st;
      int unsigned pos;
      int unsigned i;
      bit          found;
      st    = ST_DONE;
      found = 1'b0;
      pos   = 0;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (held_count >= ListDepth) begin
            st = ST_FULL;
          end else begin
            for (i = held_count; i > 0; i--) held[i] = held[i-1];
            held[0] = value;
            held_count++;
          end
        end
        CMD_PUSH_BACK: begin
          if (held_count >= ListDepth) begin
            st = ST_FULL;
          end else begin
            held[held_count] = value;
            held_count++;
          end
        end
        CMD_REMOVE: begin
          for (i = 0; i < held_count; i++) begin
            if (!found && held[i] == value) begin
              found = 1'b1;
              pos   = i;
            end
          end
          if (found) begin
            for (i = pos; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
          end else begin
            st = ST_MISSING;
          end
        end
        default: ;
      endcase
      exp_status.push_back(st);
      exp_count.push_back(held_count[CountWidth-1:0]);
    endfunction

    function void check_result(logic [1:0] status, logic [CountWidth-1:0] cnt);
      status_t               want_st;
      logic [CountWidth-1:0] want_cnt;
      if (exp_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: status %0d count %0d", status, cnt);
        return;
      end
      want_st  = exp_status.pop_front();
      want_cnt = exp_count.pop_front();
      if (status !== want_st || cnt !== want_cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected status %0d count %0d, got status %0d count %0d",
                   want_st, want_cnt, status, cnt);
      end
    endfunction

    function int unsigned pending();
      return exp_status.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   in_command;
  logic signed [ValueWidth-1:0] in_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   out_status;
  logic [CountWidth-1:0]        out_entry_count;

  list_scoreboard sb;
  int unsigned    cycles;
  bit             tx_burst;
  bit             rx_burst;
  int unsigned    rx_taken;
  bit             rx_held_off;

  bounded_ordered_list #(
    .DEPTH(ListDepth)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_status, out_entry_count);
  end

  task automatic send_word(input cmd_t cmd, input logic [ValueWidth-1:0] value);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(cmd, value);
  endtask

  function automatic logic [ValueWidth-1:0] pick_value(input bit prefer_held);
    if (prefer_held && sb.held_count > 0 && $urandom_range(0, 9) < 6)
      return sb.held[$urandom_range(0, sb.held_count - 1)];
    if ($urandom_range(0, 1) == 0)
      return ValueWidth'($urandom_range(0, 8)) - ValueWidth'(4);
    return $urandom();
  endfunction

  task automatic run_random();
    int unsigned n;
    int unsigned phase;
    int unsigned roll;
    cmd_t        cmd;
    phase = 0;
    for (n = 0; n < RandWords; n++) begin
      if (n % 40 == 0) phase = $urandom_range(0, 2);
      if ($urandom_range(0, 59) == 0) tx_burst = !tx_burst;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        cmd = CMD_NOP;
      end else if (phase == 0) begin
        cmd = (roll < 75) ? (roll[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK) : CMD_REMOVE;
      end else if (phase == 1) begin
        cmd = (roll < 30) ? (roll[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK) : CMD_REMOVE;
      end else begin
        cmd = (roll < 52) ? (roll[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK) : CMD_REMOVE;
      end
      send_word(cmd, pick_value(cmd == CMD_REMOVE));
    end
  endtask

  task automatic run_directed();
    int unsigned i;
    logic [ValueWidth-1:0] v;
    send_word(CMD_REMOVE, 32'd5);
    send_word(CMD_NOP, 32'd0);
    send_word(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_word(CMD_PUSH_FRONT, 32'd0);
    for (i = 0; i < 12; i++) begin
      v = (i % 3 == 0) ? 32'd7 : ((i % 2 == 1) ? 32'h5555_5555 : 32'hAAAA_AAAA);
      send_word(CMD_PUSH_BACK, v);
    end
    send_word(CMD_PUSH_FRONT, 32'd1);
    send_word(CMD_PUSH_BACK, 32'd1);
    send_word(CMD_REMOVE, 32'd7);
    send_word(CMD_REMOVE, 32'd0);
    send_word(CMD_REMOVE, sb.held[sb.held_count - 1]);
    send_word(CMD_REMOVE, 32'd12345);
    send_word(CMD_NOP, 32'hFFFF_FFFF);
  endtask

  initial begin
    int unsigned gap;
    out_ready   <= 1'b0;
    rx_taken    = 0;
    rx_burst    = 1'b0;
    rx_held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 13);
      if (!rx_held_off && rx_taken >= 600) begin
        rx_held_off = 1'b1;
        gap = 300;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_taken++;
    end
  end

  initial begin
    sb         = new();
    tx_burst   = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_NOP;
    in_value   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
